@@ rtl/core/per_channel_nonzero_mean_of_means_defines.svh @@
// ----------------------------------------------------------------------------
// per_channel_nonzero_mean_of_means_defines
// assertion macros for the mean-of-means block
// ----------------------------------------------------------------------------
`ifndef PER_CHANNEL_NONZERO_MEAN_OF_MEANS_DEFINES_SVH
`define PER_CHANNEL_NONZERO_MEAN_OF_MEANS_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define PCM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define PCM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/pcm_pkg.sv @@
// ----------------------------------------------------------------------------
// pcm_pkg
// shared types and constants of the per-channel mean-of-means block
// ----------------------------------------------------------------------------
package pcm_pkg;
  localparam int CHANNELS   = 256;
  localparam int COUNT_BITS = 16;
  localparam int CH_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [1:0] KIND_FILL   = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  localparam logic signed [31:0] MIN_ACCEPT_RESET = 32'sd7;

  // datapath operation codes
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1; // latch item
  localparam logic [2:0] OP_RDMEM  = 3'd2; // issue memory read at index
  localparam logic [2:0] OP_PREP   = 3'd3; // form numerator and denominator
  localparam logic [2:0] OP_DIV    = 3'd4; // one division step
  localparam logic [2:0] OP_WRITE  = 3'd5; // write back result
  localparam logic [2:0] OP_CLRW   = 3'd6; // clear long-term entry at index
  localparam logic [2:0] OP_RESULT = 3'd7; // capture read result

  typedef struct packed {
    logic [2:0] op;
    logic       upd;      // operation belongs to an update sweep
    logic       idx_inc;  // advance sweep index
    logic       idx_clr;  // zero sweep index
    logic       init_clr; // reset clearing pass write
  } pcm_cmd_t;

  typedef struct packed {
    logic       div_done;
    logic       idx_last;
    logic       fill_ok;  // fill item in range and accepted
    logic       upd_has;  // current channel has samples
    logic [1:0] kind;
  } pcm_sts_t;
endpackage

@@ rtl/core/pcm_if.sv @@
// ----------------------------------------------------------------------------
// pcm_in_if / pcm_out_if / pcm_cfg_if
// valid-ready channels of the mean-of-means block
// ----------------------------------------------------------------------------
interface pcm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  channel;
  logic signed [31:0] sample;
  modport source (output valid, kind, channel, sample, input ready);
  modport sink   (input valid, kind, channel, sample, output ready);
endinterface

interface pcm_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] mean_value;
  modport source (output valid, mean_value, input ready);
  modport sink   (input valid, mean_value, output ready);
endinterface

interface pcm_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ rtl/core/per_channel_nonzero_mean_of_means.sv @@
// ----------------------------------------------------------------------------
// per_channel_nonzero_mean_of_means
// per-channel running mean of per-instance sample means
// ----------------------------------------------------------------------------
// in channel: kind, channel, sample; one transaction per item.
// fill folds a sample into its channel's instance mean (memory read, 64 bit
// multiply-add, then the shared divider that retires one quotient bit per
// cycle).
// update sweeps all channels, one divide each.
// clear sweeps the long-term memories, one channel per cycle.
// read returns the long-term mean on the out channel via the decode, memory
// read and result states; a rejected or out-of-range fill ends at decode.
// one item is in work at a time. the out register holds its transaction
// until out_ready; no new item is taken while it waits.
// after reset a clearing pass zeroes the channel memories; in_ready stays
// low during it. cfg writes are taken any time.
// ----------------------------------------------------------------------------
module per_channel_nonzero_mean_of_means import pcm_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  pcm_in_if.sink    in_ch,
  pcm_out_if.source out_ch,
  pcm_cfg_if.sink   cfg_ch
);
  pcm_cmd_t cmd;
  pcm_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  pcm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts(sts), .cmd(cmd)
  );

  pcm_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_kind(in_ch.kind), .in_channel(in_ch.channel), .in_sample(in_ch.sample),
    .cfg_we(cfg_ch.valid), .cfg_data(cfg_ch.data), .res(out_ch.mean_value)
  );
endmodule

@@ rtl/core/pcm_div.sv @@
// ----------------------------------------------------------------------------
// pcm_div
// signed 64 by 33 bit restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pcm_div import pcm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic        [32:0] den,   // positive
  output logic               done,
  output logic signed [31:0] quo
);
  logic [63:0] q_r, q_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [32:0] den_r;
  logic        neg_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r;
  logic [33:0] trial;
  logic [63:0] mag;

  assign mag   = num[63] ? (~num + 64'd1) : num;
  assign trial = {rem_r[32:0], q_r[63]} - {1'b0, den_r};

  always_comb begin
    rem_nxt = {rem_r[32:0], q_r[63]};
    q_nxt   = {q_r[62:0], 1'b0};
    if (!trial[33]) begin
      rem_nxt  = trial;
      q_nxt[0] = 1'b1;
    end
    cnt_nxt = cnt_r + 7'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_nxt;
      if (cnt_r == 7'd63) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= mag;
      rem_r <= '0;
      den_r <= den;
      neg_r <= num[63];
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = !busy_r;
  assign quo  = neg_r ? (~q_r[31:0] + 32'd1) : q_r[31:0];
endmodule

@@ rtl/core/pcm_datapath.sv @@
// ----------------------------------------------------------------------------
// pcm_datapath
// channel memories, item registers, multiplier and divider
// ----------------------------------------------------------------------------
module pcm_datapath import pcm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  pcm_cmd_t           cmd,
  output pcm_sts_t           sts,
  input  logic [1:0]         in_kind,
  input  logic [7:0]         in_channel,
  input  logic signed [31:0] in_sample,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_data,
  output logic signed [31:0] res
);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
  localparam logic [CH_BITS:0]      IDX_ONE = (CH_BITS+1)'(1);

  logic signed [31:0] imean_mem [CHANNELS];
  logic [COUNT_BITS-1:0] icnt_mem [CHANNELS];
  logic signed [31:0] lmean_mem [CHANNELS];
  logic [31:0] itot_mem [CHANNELS];

  logic signed [31:0] min_r;
  logic [1:0]  kind_r;
  logic [7:0]  ch_r;
  logic signed [31:0] smp_r;
  logic [CH_BITS:0] idx_r;
  logic [CH_BITS-1:0] addr;
  logic signed [31:0] im_q, lm_q;
  logic [COUNT_BITS-1:0] ic_q;
  logic [31:0] it_q;
  logic signed [63:0] num_r;
  logic [32:0] den_r;
  logic        start_r;
  logic        div_done;
  logic signed [31:0] quo;
  logic signed [31:0] res_r;
  logic        in_rng;

  assign in_rng = ({{(32-8){1'b0}}, ch_r} < 32'(CHANNELS));
  assign addr   = cmd.upd || cmd.init_clr || cmd.op == OP_CLRW
                  ? idx_r[CH_BITS-1:0] : ch_r[CH_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) min_r <= MIN_ACCEPT_RESET;
    else if (cfg_we) min_r <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.idx_clr) idx_r <= '0;
    else if (cmd.idx_inc) idx_r <= idx_r + IDX_ONE;
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      kind_r <= in_kind;
      ch_r   <= in_channel;
      smp_r  <= in_sample;
    end
    if (cmd.op == OP_RDMEM) begin
      im_q <= imean_mem[addr];
      ic_q <= icnt_mem[addr];
      lm_q <= lmean_mem[addr];
      it_q <= itot_mem[addr];
    end
    start_r <= (cmd.op == OP_PREP);
    if (cmd.op == OP_PREP) begin
      if (cmd.upd) begin
        num_r <= 64'(im_q) - 64'(lm_q);
        den_r <= {1'b0, it_q} + 33'd1;
      end else begin
        num_r <= $signed({1'b0, 32'(ic_q)}) * im_q + 64'(smp_r);
        den_r <= 33'(ic_q) + 33'd1;
      end
    end
    if (cmd.init_clr) begin
      imean_mem[addr] <= '0;
      icnt_mem[addr]  <= '0;
      lmean_mem[addr] <= '0;
      itot_mem[addr]  <= '0;
    end else if (cmd.op == OP_CLRW) begin
      lmean_mem[addr] <= '0;
      itot_mem[addr]  <= '0;
    end else if (cmd.op == OP_WRITE) begin
      if (cmd.upd) begin
        if (ic_q != '0) begin
          lmean_mem[addr] <= lm_q + quo;
          imean_mem[addr] <= '0;
          icnt_mem[addr]  <= '0;
        end
        if (it_q != 32'hFFFF_FFFF) itot_mem[addr] <= it_q + 32'd1;
      end else begin
        imean_mem[addr] <= quo;
        if (ic_q != CNT_MAX) icnt_mem[addr] <= ic_q + CNT_ONE;
      end
    end
    if (cmd.op == OP_RESULT) res_r <= in_rng ? lm_q : 32'sd0;
  end

  pcm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(start_r), .num(num_r), .den(den_r),
    .done(div_done), .quo(quo)
  );

  assign sts.div_done = div_done && !start_r;
  assign sts.idx_last = (idx_r == (CH_BITS+1)'(CHANNELS - 1));
  assign sts.fill_ok  = in_rng && (smp_r >= min_r);
  assign sts.upd_has  = (ic_q != '0);
  assign sts.kind     = kind_r;
  assign res          = res_r;
endmodule

@@ rtl/core/pcm_ctrl.sv @@
// ----------------------------------------------------------------------------
// pcm_ctrl
// sequencer for fill, update sweep, clear sweep, read and reset clearing
// ----------------------------------------------------------------------------
module pcm_ctrl import pcm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  pcm_sts_t sts,
  output pcm_cmd_t cmd
);
  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_PREP  = 4'd4;
  localparam logic [3:0] S_DIVS  = 4'd5;
  localparam logic [3:0] S_DIVW  = 4'd6;
  localparam logic [3:0] S_WR    = 4'd7;
  localparam logic [3:0] S_CLR   = 4'd8;
  localparam logic [3:0] S_RES   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] st_r, st_nxt;
  logic       ov_r, ov_nxt;
  logic       upd_r, upd_nxt;

  assign in_ready  = (st_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;

  always_comb begin
    st_nxt  = st_r;
    upd_nxt = upd_r;
    ov_nxt  = ov_r && !out_ready;
    cmd     = '{op: OP_NONE, upd: upd_r, idx_inc: 1'b0, idx_clr: 1'b0, init_clr: 1'b0};
    unique case (st_r)
      S_INIT: begin
        cmd.init_clr = 1'b1;
        cmd.idx_inc  = 1'b1;
        if (sts.idx_last) begin
          cmd.idx_clr = 1'b1;
          st_nxt      = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.op  = OP_LOAD;
          st_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        cmd.idx_clr = 1'b1;
        upd_nxt     = 1'b0;
        case (sts.kind)
          KIND_FILL:   st_nxt = sts.fill_ok ? S_RD : S_IDLE;
          KIND_UPDATE: begin upd_nxt = 1'b1; st_nxt = S_RD; end
          KIND_CLEAR:  st_nxt = S_CLR;
          default:     st_nxt = S_RD;
        endcase
      end
      S_RD: begin
        cmd.op = OP_RDMEM;
        st_nxt = (sts.kind == KIND_READ) ? S_RES : S_PREP;
      end
      S_PREP: begin
        cmd.op = OP_PREP;
        st_nxt = S_DIVS;
      end
      S_DIVS: st_nxt = S_DIVW;
      S_DIVW: if (sts.div_done) st_nxt = S_WR;
      S_WR: begin
        cmd.op = OP_WRITE;
        if (upd_r && !sts.idx_last) begin
          cmd.idx_inc = 1'b1;
          st_nxt      = S_RD;
        end else begin
          st_nxt = S_IDLE;
        end
      end
      S_CLR: begin
        cmd.op      = OP_CLRW;
        cmd.idx_inc = 1'b1;
        if (sts.idx_last) st_nxt = S_IDLE;
      end
      S_RES: begin
        cmd.op = OP_RESULT;
        st_nxt = S_DONE;
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_INIT;
      ov_r  <= 1'b0;
      upd_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      ov_r  <= ov_nxt;
      upd_r <= upd_nxt;
    end
  end
endmodule

@@ rtl/core/pcm_checker.sv @@
// ----------------------------------------------------------------------------
// pcm_checker
// port-level checks of the mean-of-means block
// ----------------------------------------------------------------------------
`include "per_channel_nonzero_mean_of_means_defines.svh"
module pcm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [31:0] out_mean_value
);
  // one item at a time: no accept while a result waits
  `PCM_ASSERT_IMP(a_no_in_while_out, clk, rst_n, out_valid, !in_ready, "accept with result pending")
  // a result waiting keeps its value
  `PCM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_mean_value), "stalled result changed")
  // an accepted item blocks the next accept in the following cycle
  `PCM_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "back-to-back accept")
  // a result never shows up right after an accept
  `PCM_ASSERT_NXT(a_no_early_out, clk, rst_n, in_valid && in_ready && !out_valid, !out_valid, "result too early")
endmodule

bind per_channel_nonzero_mean_of_means pcm_checker u_pcm_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_mean_value(out_ch.mean_value)
);
